// ----- rtl/core/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// Used by the top level, the quotient tracker and the port checker.
`default_nettype none

package uer_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 4;

  // Echo round trip time per centimeter of distance, in microseconds.
  localparam int US_PER_CM = 58;

  localparam int DIST_W = 15;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Input tdata bit positions.
  localparam int S_START_BIT = 0;
  localparam int S_ECHO_BIT  = 1;

  // Output tdata bit positions.
  localparam int M_TRIG_BIT    = 0;
  localparam int M_DONE_BIT    = 1;
  localparam int M_DIST_LSB    = 2;
  localparam int M_DIST_MSB    = M_DIST_LSB + DIST_W - 1;
  localparam int M_VALID_BIT   = M_DIST_MSB + 1;
  localparam int M_INRANGE_BIT = M_VALID_BIT + 1;
  localparam int M_ENTER_BIT   = M_INRANGE_BIT + 1;
  localparam int M_LEFT_BIT    = M_ENTER_BIT + 1;
  localparam int M_USED_W      = M_LEFT_BIT + 1;

  // Register reset values.
  localparam logic [7:0]  TRIG_WIDTH_RST   = 8'd10;
  localparam logic [15:0] RISE_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] HIGH_TIMEOUT_RST = 16'd30000;
  localparam logic [9:0]  MAX_RANGE_RST    = 10'd400;
  localparam logic [9:0]  THRESHOLD_RST    = 10'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TRIG_WIDTH   = 3'd0,
    REG_RISE_TIMEOUT = 3'd1,
    REG_HIGH_TIMEOUT = 3'd2,
    REG_MAX_RANGE    = 3'd3,
    REG_THRESHOLD    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_t;

  // Control for the running quotient: load sets it for one tick, step adds a tick.
  typedef struct packed {
    logic load;
    logic step;
  } uer_quot_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/uer_quot.sv -----
// Running quotient of (ticks << FRACTION_BITS) / 58, kept alongside the echo count.
// Depends on uer_pkg for the control struct and the divisor constant.
`default_nettype none

module uer_quot
  import uer_pkg::*;
#(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int QW = COUNT_WIDTH + FRACTION_BITS - 5
) (
  input  wire logic           clk,
  input  wire uer_quot_ctrl_t ctrl,
  output logic [QW-1:0]       q_next
);

  localparam int RW = 6;
  localparam int Q_STEP_I = (1 << FRACTION_BITS) / US_PER_CM;
  localparam int R_STEP_I = (1 << FRACTION_BITS) % US_PER_CM;
  localparam logic [QW-1:0]  Q_STEP = QW'(Q_STEP_I);
  localparam logic [RW-1:0]  R_STEP = RW'(R_STEP_I);
  localparam logic [RW:0]    DIV_C  = (RW + 1)'(US_PER_CM);

  logic [QW-1:0] q;
  logic [RW-1:0] r;
  logic [RW-1:0] r_next;
  logic [RW:0]   r_sum;
  logic          carry;

  // Each tick adds 2^FRACTION_BITS to the dividend; the remainder stays below 58.
  always_comb begin
    r_sum = {1'b0, r} + {1'b0, R_STEP};
    carry = (r_sum >= DIV_C);
    q_next = q;
    r_next = r;
    if (ctrl.load) begin
      q_next = Q_STEP;
      r_next = R_STEP;
    end else if (ctrl.step) begin
      q_next = q + Q_STEP + QW'(carry);
      r_next = carry ? RW'(r_sum - DIV_C) : r_sum[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    r <= r_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Ultrasonic ranging controller, top level.
// Depends on uer_pkg and uer_quot.
//
// Usage: every transfer on the s_* channel is one microsecond tick carrying
// the echo pin level and a start request. Every input transfer yields exactly
// one transfer on the m_* channel with the trigger drive level for that tick
// and, on the tick a measurement ends, the distance in cm (Q.FRACTION_BITS),
// its valid flag and the in-range, entered and left flags. On other ticks the
// last distance and in-range flag are repeated with done, valid, entered and
// left low. Configuration is written through cfg_wen/cfg_addr/cfg_wdata and
// takes effect on the next tick.
// The result sits in the output register the cycle after the input transfer.
// Throughput is one tick per cycle while the receiver takes each result, set
// by the single output register; the quotient is tracked incrementally tick by
// tick, so no divider stands in the path.
// A synchronous reset returns the sequencer to idle, clears the held result
// and empties the output register. When the receiver stalls with a result
// waiting, s_tready drops until that result is taken.
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_DATA_W-1:0]   s_tdata,   // start_req, echo, zero fill
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // trigger, done_res, distance_q4[14:0], distance_valid, in_range, entered, left, zero fill
  output logic [M_DATA_W-1:0]        m_tdata,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QW   = COUNT_WIDTH + FRACTION_BITS - 5;
  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int QXW  = (QW > DIST_W) ? QW : DIST_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [15:0] US_PER_CM_16 = 16'(US_PER_CM);

  // Configuration registers.
  logic [7:0]  trig_width;
  logic [15:0] rise_timeout;
  logic [15:0] high_timeout;
  logic [9:0]  max_range;
  logic [9:0]  threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_width   <= TRIG_WIDTH_RST;
      rise_timeout <= RISE_TIMEOUT_RST;
      high_timeout <= HIGH_TIMEOUT_RST;
      max_range    <= MAX_RANGE_RST;
      threshold    <= THRESHOLD_RST;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TRIG_WIDTH:   trig_width   <= cfg_wdata[7:0];
        REG_RISE_TIMEOUT: rise_timeout <= cfg_wdata;
        REG_HIGH_TIMEOUT: high_timeout <= cfg_wdata;
        REG_MAX_RANGE:    max_range    <= cfg_wdata[9:0];
        REG_THRESHOLD:    threshold    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [DIST_W-1:0]      held_dist;
  logic                   last_in;

  logic accept;
  logic start_req;
  logic echo;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign start_req = s_tdata[S_START_BIT];
  assign echo      = s_tdata[S_ECHO_BIT];

  // Zero widths and timeouts behave as one.
  logic [CMPW-1:0] tw_eff;
  logic [CMPW-1:0] rt_eff;
  logic [CMPW-1:0] ht_eff;
  logic [CMPW-1:0] cnt_inc_x;

  assign tw_eff    = (trig_width == '0)   ? CMPW'(1) : CMPW'(trig_width);
  assign rt_eff    = (rise_timeout == '0) ? CMPW'(1) : CMPW'(rise_timeout);
  assign ht_eff    = (high_timeout == '0) ? CMPW'(1) : CMPW'(high_timeout);
  assign cnt_inc   = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
  assign cnt_inc_x = CMPW'(cnt_inc);

  uer_quot_ctrl_t         qctl;
  logic [QW-1:0]          q_next;
  logic                   trig;
  logic                   fin;
  logic                   fin_rose;
  logic [COUNT_WIDTH-1:0] fin_ticks;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    qctl       = '0;
    trig       = 1'b0;
    fin        = 1'b0;
    fin_rose   = 1'b0;
    fin_ticks  = cnt;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          trig = 1'b1;
          if (tw_eff <= CMPW'(1)) begin
            phase_next = PH_RISE;
            cnt_next   = '0;
          end else begin
            phase_next = PH_TRIG;
            cnt_next   = COUNT_WIDTH'(1);
          end
        end
      end
      PH_TRIG: begin
        trig     = 1'b1;
        cnt_next = cnt_inc;
        if (cnt_inc_x >= tw_eff) begin
          phase_next = PH_RISE;
          cnt_next   = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          // The rise tick is the first high tick.
          phase_next = PH_HIGH;
          cnt_next   = COUNT_WIDTH'(1);
          qctl.load  = 1'b1;
          if (ht_eff <= CMPW'(1)) begin
            fin       = 1'b1;
            fin_rose  = 1'b1;
            fin_ticks = COUNT_WIDTH'(1);
          end
        end else begin
          cnt_next = cnt_inc;
          if (cnt_inc_x >= rt_eff) begin
            fin       = 1'b1;
            fin_ticks = '0;
          end
        end
      end
      PH_HIGH: begin
        fin_rose = 1'b1;
        if (!echo) begin
          fin = 1'b1;
        end else begin
          cnt_next  = cnt_inc;
          qctl.step = (cnt != COUNT_MAX);
          fin_ticks = cnt_inc;
          if (cnt_inc_x >= ht_eff || cnt_inc == COUNT_MAX) begin
            fin = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        cnt_next   = '0;
      end
    endcase
    if (fin) begin
      phase_next = PH_IDLE;
      cnt_next   = '0;
    end
  end

  uer_quot #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_quot (
    .clk    (clk),
    .ctrl   (accept ? qctl : uer_quot_ctrl_t'('0)),
    .q_next (q_next)
  );

  // Result of a finished measurement; the limits are exact tick counts.
  logic [CMPW-1:0]   ticks_x;
  logic [CMPW-1:0]   max_lim;
  logic [CMPW-1:0]   thr_lim;
  logic [QXW-1:0]    q_x;
  logic              dist_ok;
  logic              now_in;
  logic [DIST_W-1:0] dist_fin;

  assign ticks_x  = CMPW'(fin_ticks);
  assign max_lim  = CMPW'(16'(max_range) * US_PER_CM_16);
  assign thr_lim  = CMPW'(16'(threshold) * US_PER_CM_16);
  assign q_x      = QXW'(q_next);
  assign dist_ok  = fin_rose && (ticks_x != '0) && (ticks_x < max_lim);
  assign now_in   = dist_ok && (ticks_x <= thr_lim);
  assign dist_fin = !dist_ok ? '0 :
                    (q_x > QXW'(DIST_MAX)) ? DIST_MAX : q_x[DIST_W-1:0];

  logic [M_USED_W-1:0] result;

  always_comb begin
    if (fin) begin
      result = {!now_in && last_in, now_in && !last_in, now_in, dist_ok,
                dist_fin, 1'b1, trig};
    end else begin
      result = {1'b0, 1'b0, last_in, 1'b0, held_dist, 1'b0, trig};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      held_dist <= '0;
      last_in   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      if (fin) begin
        held_dist <= dist_fin;
        last_in   <= now_in;
      end
    end
  end

  // Output register: a new tick is taken while it is empty or the receiver accepts this one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= M_DATA_W'(result);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/uer_checker.sv -----
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg for the output field positions.
`default_nettype none

module uer_checker
  import uer_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // A result that waits for the receiver holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // Outside the tick that ends a measurement, no event or valid flag shows.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[M_DONE_BIT] |->
      !m_tdata[M_VALID_BIT] && !m_tdata[M_ENTER_BIT] && !m_tdata[M_LEFT_BIT])
    else $error("flags raised on a tick without done");

  // An invalid measurement reports zero distance and is never in range.
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_DONE_BIT] && !m_tdata[M_VALID_BIT] |->
      (m_tdata[M_DIST_MSB:M_DIST_LSB] == '0) && !m_tdata[M_INRANGE_BIT]
      && !m_tdata[M_ENTER_BIT])
    else $error("invalid result carries distance or range");

  // Entered goes with in range, left with out of range.
  a_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[M_ENTER_BIT] && !m_tdata[M_INRANGE_BIT])
      && !(m_tdata[M_LEFT_BIT] && m_tdata[M_INRANGE_BIT]))
    else $error("entered or left disagrees with in_range");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
